// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned TAB_STOP   = 4;
  localparam int unsigned TAB_W      = $clog2(TAB_STOP);

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CELL_W = ATTR_W + CHAR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NULL    = 8'd0;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHAR,
    ST_TAB_FIRST,
    ST_TAB_MORE,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PTR_SCROLL_SRC,
    PTR_FILL,
    PTR_ZERO
  } ptr_init_e;

  typedef struct packed {
    logic      load_item;
    logic      ptr_load;
    ptr_init_e ptr_init;
    logic      ptr_inc;
    logic      copy_step;
    logic      fill_wr;
    logic      fill_space;
    logic      cell_wr;
    logic      cell_space;
    logic      read_cell;
    logic      row_inc;
    logic      col_zero;
    logic      col_inc;
    logic      cur_home;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            is_newline;
    logic            is_return;
    logic            is_tab;
    logic            row_last;
    logic            col_wrap;
    logic            col_lt_last;
    logic            col_on_stop;
    logic            ptr_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tcw_pkg::in_item_t  in_item_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire tcw_pkg::cmd_t      cmd_i,
  output tcw_pkg::status_t        status_o,
  output tcw_pkg::out_item_t      out_item_o
);

  tcw_pkg::in_item_t                 item_q;
  tcw_pkg::out_item_t                out_q;
  logic [tcw_pkg::ATTR_W-1:0]        attr_q;
  logic [tcw_pkg::ROW_W-1:0]         row_q;
  logic [tcw_pkg::COL_W-1:0]         col_q;
  logic [tcw_pkg::ADDR_W-1:0]        ptr_q;
  logic                              pend_q;
  logic [tcw_pkg::ADDR_W-1:0]        pend_addr_q;
  logic [tcw_pkg::CELL_W-1:0]        rd_data_q;

  logic [tcw_pkg::CELL_W-1:0]        mem [tcw_pkg::CELL_COUNT];

  logic [tcw_pkg::ADDR_W-1:0]        cur_addr;
  logic [tcw_pkg::ADDR_W-1:0]        rd_addr;
  logic                              rd_en;
  logic                              idx_ok;
  logic [tcw_pkg::CELL_W-1:0]        fill_word;
  logic [tcw_pkg::CELL_W-1:0]        put_word;

  assign cur_addr = tcw_pkg::ADDR_W'(32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q));
  assign idx_ok   = item_q.cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT);
  assign rd_en    = cmd_i.copy_step | (cmd_i.read_cell & idx_ok);
  assign rd_addr  = cmd_i.copy_step ? ptr_q : tcw_pkg::ADDR_W'(item_q.cell_index);

  assign fill_word = {attr_q, cmd_i.fill_space ? tcw_pkg::CH_SPACE : tcw_pkg::CH_NULL};
  assign put_word  = {attr_q, cmd_i.cell_space ? tcw_pkg::CH_SPACE : item_q.char_code};

  // scroll copy: a read issued this cycle is written back one row up next cycle
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[pend_addr_q] <= rd_data_q;
    end else if (cmd_i.fill_wr) begin
      mem[ptr_q] <= fill_word;
    end else if (cmd_i.cell_wr) begin
      mem[cur_addr] <= put_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= ptr_q - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.out_load) begin
      out_q.cursor_row <= row_q;
      out_q.cursor_col <= col_q;
      out_q.cell_word  <= (item_q.opcode == tcw_pkg::OP_READ && idx_ok) ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
      row_q  <= '0;
      col_q  <= '0;
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy_step;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.cur_home) begin
        row_q <= '0;
        col_q <= '0;
      end else begin
        if (cmd_i.row_inc) begin
          row_q <= row_q + 1'b1;
        end
        if (cmd_i.col_zero) begin
          col_q <= '0;
        end else if (cmd_i.col_inc) begin
          col_q <= col_q + 1'b1;
        end
      end
      if (cmd_i.ptr_load) begin
        case (cmd_i.ptr_init)
          tcw_pkg::PTR_SCROLL_SRC: ptr_q <= tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
          tcw_pkg::PTR_FILL:
            ptr_q <= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
          tcw_pkg::PTR_ZERO:       ptr_q <= '0;
          default:                 ptr_q <= '0;
        endcase
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_comb begin
    status_o.opcode      = item_q.opcode;
    status_o.is_newline  = item_q.char_code == tcw_pkg::CH_NEWLINE;
    status_o.is_return   = item_q.char_code == tcw_pkg::CH_RETURN;
    status_o.is_tab      = item_q.char_code == tcw_pkg::CH_TAB;
    status_o.row_last    = row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    status_o.col_wrap    = col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    status_o.col_lt_last = col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    status_o.col_on_stop = col_q[tcw_pkg::TAB_W-1:0] == '0;
    status_o.ptr_last    = ptr_q == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  end

  assign out_item_o = out_q;

  // single write port: a pending copy never meets another write
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(cmd_i.fill_wr || cmd_i.cell_wr))
    else $error("write port clash during scroll copy");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS) && col_q <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    else $error("cursor out of range");

  a_cell_write_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cell_wr |-> col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    else $error("cell write at pending wrap column");

endmodule

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t         cmd_o
);

  tcw_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            need_nl;
  tcw_pkg::state_e after_nl;

  assign out_free = !out_valid_q || !out_stall_i;
  // tab and plain characters resolve a pending wrap with a newline first
  assign need_nl  = status_i.is_newline || status_i.col_wrap;
  assign after_nl = status_i.is_newline ? tcw_pkg::ST_DONE :
                    status_i.is_tab     ? tcw_pkg::ST_TAB_FIRST : tcw_pkg::ST_CHAR;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tcw_pkg::ST_DISPATCH;
        end
      end
      tcw_pkg::ST_DISPATCH: begin
        case (status_i.opcode)
          tcw_pkg::OP_PUT: begin
            if (status_i.is_return) begin
              state_d = tcw_pkg::ST_DONE;
            end else if (need_nl && status_i.row_last) begin
              state_d = tcw_pkg::ST_SCROLL;
            end else begin
              state_d = after_nl;
            end
          end
          tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
          tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_READ;
          default:           state_d = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_CHAR: state_d = tcw_pkg::ST_DONE;
      tcw_pkg::ST_TAB_FIRST: begin
        state_d = status_i.col_lt_last ? tcw_pkg::ST_TAB_MORE : tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_TAB_MORE: begin
        if (!status_i.col_lt_last || status_i.col_on_stop) begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (status_i.ptr_last) begin
          state_d = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: state_d = tcw_pkg::ST_FILL;
      tcw_pkg::ST_FILL: begin
        if (status_i.ptr_last) begin
          state_d = after_nl;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (status_i.ptr_last) begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.ptr_init = tcw_pkg::PTR_ZERO;
    in_stall_o     = 1'b1;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      tcw_pkg::ST_DISPATCH: begin
        case (status_i.opcode)
          tcw_pkg::OP_PUT: begin
            if (status_i.is_return) begin
              cmd_o.col_zero = 1'b1;
            end else if (need_nl && status_i.row_last) begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_init = tcw_pkg::PTR_SCROLL_SRC;
            end else if (need_nl) begin
              cmd_o.row_inc  = 1'b1;
              cmd_o.col_zero = 1'b1;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_init = tcw_pkg::PTR_ZERO;
            cmd_o.cur_home = 1'b1;
          end
          default: ;
        endcase
      end
      tcw_pkg::ST_CHAR: begin
        cmd_o.cell_wr = 1'b1;
        cmd_o.col_inc = 1'b1;
      end
      tcw_pkg::ST_TAB_FIRST: begin
        cmd_o.cell_wr    = status_i.col_lt_last;
        cmd_o.cell_space = 1'b1;
        cmd_o.col_inc    = status_i.col_lt_last;
      end
      tcw_pkg::ST_TAB_MORE: begin
        cmd_o.cell_wr    = status_i.col_lt_last && !status_i.col_on_stop;
        cmd_o.cell_space = 1'b1;
        cmd_o.col_inc    = status_i.col_lt_last && !status_i.col_on_stop;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd_o.copy_step = 1'b1;
        cmd_o.ptr_inc   = 1'b1;
      end
      tcw_pkg::ST_DRAIN: begin
        cmd_o.ptr_load = 1'b1;
        cmd_o.ptr_init = tcw_pkg::PTR_FILL;
      end
      tcw_pkg::ST_FILL: begin
        cmd_o.fill_wr  = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        cmd_o.col_zero = status_i.ptr_last;
      end
      tcw_pkg::ST_CLEAR: begin
        cmd_o.fill_wr    = 1'b1;
        cmd_o.fill_space = 1'b1;
        cmd_o.ptr_inc    = 1'b1;
      end
      tcw_pkg::ST_READ: begin
        cmd_o.read_cell = 1'b1;
      end
      tcw_pkg::ST_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == tcw_pkg::ST_DISPATCH)
    else $error("accepted item not dispatched");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_DONE && out_free |=> out_valid_q && state_q == tcw_pkg::ST_IDLE)
    else $error("finished item not registered at output");

  a_drain_after_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_DRAIN |-> $past(state_q) == tcw_pkg::ST_SCROLL)
    else $error("drain entered outside a scroll");

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// plain character or read: the item is decoded in dispatch, handled in its own state and its
// result registered in done; a tab writes spaces up to the next tab stop before done; return,
// newline without scroll or an idle opcode: straight from dispatch to done; a new item is taken
// only once the result is registered. a scroll copies one cell per cycle through the single
// screen ram write port, a clear one cell per cycle; a stalled result holds the next item back.
// reset: cursor home, attribute 7; screen contents undefined until the first clear.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tcw_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tcw_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== verif/text_console_writer_check.sv =====
`timescale 1ns / 1ps

module text_console_writer_check
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_item_i,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  output int                results_o,
  output int                errors_o,
  output int                pending_o
);

  // shadow copy of the screen, cursor and attribute
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  int unsigned       row_q;
  int unsigned       col_q;
  logic [ATTR_W-1:0] attr_q;
  out_item_t         cursor_q [$];
  int                n_results;
  int                n_errors;

  function automatic logic [CELL_W-1:0] cell_of(input logic [CHAR_W-1:0] ch);
    return {attr_q, ch};
  endfunction

  task automatic line_feed();
    if (row_q + 1 < ROWS) begin
      row_q++;
    end else begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
      // bottom row gets null characters, not spaces
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_mem[i] = cell_of(CH_NULL);
    end
    col_q = 0;
  endtask

  task automatic predict_console(input in_item_t it);
    out_item_t   res;
    int unsigned span;
    res = '0;
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == CH_NEWLINE) begin
          line_feed();
        end else if (it.char_code == CH_RETURN) begin
          col_q = 0;
        end else if (it.char_code == CH_TAB) begin
          if (col_q >= COLUMNS) line_feed();
          span = TAB_STOP - col_q % TAB_STOP;
          // tab never pads into the last column
          if (span + col_q > COLUMNS - 1) span = COLUMNS - 1 - col_q;
          repeat (span) begin
            screen_mem[row_q * COLUMNS + col_q] = cell_of(CH_SPACE);
            col_q++;
          end
        end else begin
          if (col_q >= COLUMNS) line_feed();
          screen_mem[row_q * COLUMNS + col_q] = cell_of(it.char_code);
          col_q++;
        end
      end
      OP_CLEAR: begin
        row_q = 0;
        col_q = 0;
        foreach (screen_mem[i]) screen_mem[i] = cell_of(CH_SPACE);
      end
      OP_READ: begin
        if (it.cell_index < CELL_COUNT) res.cell_word = screen_mem[it.cell_index];
      end
      default: ; // unused opcode leaves everything alone
    endcase
    res.cursor_row = row_q[ROW_W-1:0];
    res.cursor_col = col_q[COL_W-1:0];
    cursor_q.push_back(res);
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (cursor_q.size() == 0) begin
      $error("unexpected item: cursor_row %0d cursor_col %0d cell_word %h",
             got.cursor_row, got.cursor_col, got.cell_word);
      n_errors++;
    end else begin
      want = cursor_q.pop_front();
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row expected %0d actual %0d", want.cursor_row, got.cursor_row);
        n_errors++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col expected %0d actual %0d", want.cursor_col, got.cursor_col);
        n_errors++;
      end
      if (got.cell_word !== want.cell_word) begin
        $error("cell_word expected %h actual %h", want.cell_word, got.cell_word);
        n_errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     = 0;
      col_q     = 0;
      attr_q    = ATTR_RESET;
      n_results = 0;
      n_errors  = 0;
      cursor_q.delete();
      results_o <= 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_result(out_item_i);
        n_results++;
      end
      if (in_valid_i && !in_stall_i) predict_console(in_item_i);
      if (cfg_we_i) attr_q = cfg_wdata_i;
      results_o <= n_results;
      errors_o  <= n_errors;
      pending_o <= cursor_q.size();
    end
  end

endmodule

// ===== verif/text_console_writer_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int          HALF_PERIOD   = 2;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_we    = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;

  int          check_results;
  int          check_errors;
  int          check_pending;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  text_console_writer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  text_console_writer_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .results_o   (check_results),
    .errors_o    (check_errors),
    .pending_o   (check_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.opcode     = op;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    if ($urandom_range(19) == 0) return CHAR_W'($urandom_range(255));
    return CHAR_W'($urandom_range(126, 32));
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(make_item(OP_PUT, ch, IDX_W'($urandom_range(2047))));
  endtask

  task automatic read_cell(input int unsigned idx);
    send_item(make_item(OP_READ, CHAR_W'($urandom_range(255)), IDX_W'(idx)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (check_results != items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_attr(input logic [ATTR_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // a line of text; many end right at the edge to hit wrap and tab clamping
        len = ($urandom_range(9) < 3) ? $urandom_range(80, 76) : $urandom_range(90, 1);
        repeat (len) put_char(text_char());
        pick = $urandom_range(9);
        if (pick < 5) put_char(CH_NEWLINE);
        else if (pick < 7) put_char(CH_RETURN);
        else if (pick < 9) put_char(CH_TAB);
      end else if (pick < 70) begin
        repeat ($urandom_range(12, 1)) put_char(($urandom_range(9) < 4) ? CH_TAB : text_char());
      end else if (pick < 85) begin
        repeat ($urandom_range(8, 1)) read_cell($urandom_range(2047));
      end else if (pick < 95) begin
        pick = $urandom_range(2);
        send_item(make_item(pick == 0 ? OP_PUT : (pick == 1 ? OP_READ : OP_UNUSED),
                            CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047))));
      end else if (pick < 97) begin
        send_item(make_item(OP_CLEAR, CHAR_W'($urandom_range(255)),
                            IDX_W'($urandom_range(2047))));
      end else begin
        // long newline runs reach the bottom row and scroll
        repeat ($urandom_range(30, 1)) put_char(CH_NEWLINE);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 30;
    recv_stall_pct <= 55;

    // clear first so that every later in-range read hits a written cell
    send_item(make_item(OP_CLEAR, 8'hFF, 11'h7FF));
    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell(11'h7FF);
    put_char(8'h41);
    put_char(CH_NULL);
    put_char(8'hFF);
    put_char(CH_TAB);
    put_char(CH_TAB);
    read_cell(1);
    read_cell(3);
    read_cell(7);
    put_char(CH_RETURN);
    put_char(CH_NEWLINE);
    send_item(make_item(OP_UNUSED, 8'hFF, 11'h7FF));
    put_char(8'h7E);
    read_cell(COLUMNS);
    read_cell(0);

    set_attr(8'hFF);
    run_random(700);

    set_attr(8'h00);
    send_idle_pct = 55;
    recv_stall_pct <= 30;
    run_random(700);

    set_attr(ATTR_W'($urandom_range(255)));
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // long result hold-off while items keep coming, so the input backs up
    hold_req <= hold_req + 1;
    run_random(600);

    wait_drained();
    if (check_errors == 0 && check_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_datapath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
verif/text_console_writer_check.sv
verif/text_console_writer_test.sv
